### hdl/gn1d_pkg.sv
// ----------------------------------------------------------------------------
// gn1d_pkg
// shared widths and constants of the 1d gradient noise block
// ----------------------------------------------------------------------------
package gn1d_pkg;

  // permutation table, a power of two in 2..256
  localparam int unsigned TableEntries = 256;
  localparam int unsigned IdxW         = $clog2(TableEntries);

  // only the low four bits of an entry take part in the gradient
  localparam int unsigned EntryW       = 4;

  // item fields
  localparam int unsigned ActionW      = 1;
  localparam int unsigned EntryIndexW  = 8;
  localparam int unsigned EntryValueW  = 8;
  localparam int unsigned CoordW       = 32;
  localparam int unsigned NoiseW       = 24;

  // fixed point
  localparam int unsigned FracW        = 16;

  // pipeline depth, output register included
  localparam int unsigned NumStages    = 8;

  typedef enum logic [ActionW-1:0] {
    ActLoad = 1'b0,
    ActEval = 1'b1
  } action_e;

  typedef logic [IdxW-1:0]   idx_t;
  typedef logic [EntryW-1:0] entry_t;
  typedef logic [FracW-1:0]  frac_t;

endpackage

### hdl/gn1d_if.sv
// ----------------------------------------------------------------------------
// gn1d channel interfaces
// request channel (load or evaluate) and noise result channel
// ----------------------------------------------------------------------------
interface gn1d_req_if;
  import gn1d_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [ActionW-1:0]     action;
  logic [EntryIndexW-1:0] entry_index;
  logic [EntryValueW-1:0] entry_value;
  logic [CoordW-1:0]      coordinate;

  modport source (
    output valid, action, entry_index, entry_value, coordinate,
    input  ready
  );
  modport sink (
    input  valid, action, entry_index, entry_value, coordinate,
    output ready
  );
endinterface

interface gn1d_rsp_if;
  import gn1d_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [NoiseW-1:0] noise_value;

  modport source (
    output valid, noise_value,
    input  ready
  );
  modport sink (
    input  valid, noise_value,
    output ready
  );
endinterface

### hdl/gradient_noise_1d.sv
// ----------------------------------------------------------------------------
// gradient_noise_1d
// one-dimensional perlin gradient noise, unsigned q16.16 in, signed q7.16 out
// ----------------------------------------------------------------------------
//
//  channel  dir  beat contents                                    port
//  -------  ---  -----------------------------------------------  -----
//  req      in   action, entry_index, entry_value, coordinate     req_i
//  rsp      out  noise_value (signed q7.16)                       rsp_o
//
//  one beat per cycle in and out while the output is not stalled; an evaluate
//  beat gives its result through the eight register stages of the datapath
//  a load beat writes the table at its accept edge and gives no result
//  each stage stalls only while it is full and the stage after it is blocked,
//  so empty stages keep filling while a result waits at the output
//  reset clears the stage valid bits; the table is undefined until loaded
//
module gradient_noise_1d (
  input  logic              clk_i,
  input  logic              rst_ni,
  gn1d_req_if.sink          req_i,
  gn1d_rsp_if.source        rsp_o
);
  import gn1d_pkg::*;

  // stage valid bits and per-stage advance enables
  logic [NumStages-1:0] valid_q;
  logic [NumStages-1:0] adv;

  // accept decode
  logic req_acc;
  logic load_acc;
  logic eval_acc;

  // permutation table, low nibble of each entry only
  entry_t perm_mem [TableEntries];

  idx_t wr_idx;
  idx_t rd_idx0;
  idx_t rd_idx1;

  // stage 0: table read
  frac_t  f0_q;
  entry_t e0_q;
  entry_t e1_q;

  // stage 1: f^2 and the two gradient products
  logic [3:0]         g0_mag;
  logic [3:0]         g1_mag;
  logic [FracW:0]     one_minus_f;
  logic [19:0]        ga_prod;
  logic [20:0]        gb_prod;
  frac_t              f1_q;
  logic [31:0]        sq1_d,  sq1_q;
  logic signed [20:0] ga1_d,  ga1_q;
  logic signed [20:0] gb1_d,  gb1_q;

  // stage 2: f^3 product, fade polynomial rounded to q16, gradient difference
  logic [35:0]        sq_x6;
  logic [35:0]        f_x15;
  logic [35:0]        poly;
  logic [35:0]        poly_rnd;
  logic [47:0]        cube_raw2_d, cube_raw2_q;
  logic [19:0]        p16_2_d,     p16_2_q;
  logic signed [20:0] ga2_q;
  logic signed [21:0] diff2_d,     diff2_q;

  // stage 3: round f^3 to q32
  logic [47:0]        cube_rnd;
  logic [31:0]        cube3_d, cube3_q;
  logic [19:0]        p16_3_q;
  logic signed [20:0] ga3_q;
  logic signed [21:0] diff3_q;

  // stage 4: t^3 times polynomial
  logic [51:0]        uprod4_d, uprod4_q;
  logic signed [20:0] ga4_q;
  logic signed [21:0] diff4_q;

  // stage 5: fade weight u in q16
  logic [51:0]        uprod_rnd;
  logic [FracW:0]     u5_d, u5_q;
  logic signed [20:0] ga5_q;
  logic signed [21:0] diff5_q;

  // stage 6: u times gradient difference
  logic signed [FracW+1:0] u_s;
  logic signed [39:0]      m6_d, m6_q;
  logic signed [20:0]      ga6_q;

  // stage 7: blend and output scaling
  logic signed [39:0]       m_rnd;
  logic signed [NoiseW-1:0] blend;
  logic signed [NoiseW-1:0] noise_d, noise_q;

  // --------------------------------------------------------------------------
  // handshake and stage enables
  // --------------------------------------------------------------------------

  // a stage moves when it is empty or the stage after it moves
  always_comb begin
    adv[NumStages-1] = !valid_q[NumStages-1] || rsp_o.ready;
    for (int k = NumStages - 2; k >= 0; k--) begin
      adv[k] = !valid_q[k] || adv[k+1];
    end
  end

  assign req_i.ready = adv[0];
  assign req_acc     = req_i.valid && adv[0];
  assign load_acc    = req_acc && (action_e'(req_i.action) == ActLoad);
  assign eval_acc    = req_acc && (action_e'(req_i.action) == ActEval);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (adv[0]) begin
        valid_q[0] <= eval_acc;
      end
      for (int k = 1; k < NumStages; k++) begin
        if (adv[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // permutation table: one write port, two registered read ports
  // --------------------------------------------------------------------------

  assign wr_idx  = IdxW'(req_i.entry_index);
  assign rd_idx0 = req_i.coordinate[FracW +: IdxW];
  // neighbor of the last entry wraps to entry zero
  assign rd_idx1 = rd_idx0 + IdxW'(1);

  always_ff @(posedge clk_i) begin
    if (load_acc) begin
      perm_mem[wr_idx] <= req_i.entry_value[EntryW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      e0_q <= perm_mem[rd_idx0];
      e1_q <= perm_mem[rd_idx1];
      f0_q <= req_i.coordinate[FracW-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: gradients, bits 2..0 give magnitude 1..8, bit 3 the sign
  // --------------------------------------------------------------------------

  assign g0_mag      = {1'b0, e0_q[2:0]} + 4'd1;
  assign g1_mag      = {1'b0, e1_q[2:0]} + 4'd1;
  assign one_minus_f = {1'b1, {FracW{1'b0}}} - {1'b0, f0_q};
  assign ga_prod     = 20'(f0_q) * 20'(g0_mag);
  assign gb_prod     = 21'(one_minus_f) * 21'(g1_mag);
  assign sq1_d       = 32'(f0_q) * 32'(f0_q);

  // ga = g0 * f
  assign ga1_d = e0_q[3] ? -$signed({1'b0, ga_prod}) : $signed({1'b0, ga_prod});
  // gb = g1 * (f - 1), offset is negative so the sign flips
  assign gb1_d = e1_q[3] ? $signed(gb_prod) : -$signed(gb_prod);

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      f1_q  <= f0_q;
      sq1_q <= sq1_d;
      ga1_q <= ga1_d;
      gb1_q <= gb1_d;
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: quintic fade, poly = 10 - 15t + 6t^2 in q32, rounded to q16
  // --------------------------------------------------------------------------

  assign sq_x6       = {2'b0, sq1_q, 2'b0} + {3'b0, sq1_q, 1'b0};
  assign f_x15       = {({4'b0, f1_q} << 4) - {4'b0, f1_q}, {FracW{1'b0}}};
  assign poly        = {4'd10, 32'd0} + sq_x6 - f_x15;
  assign poly_rnd    = poly + 36'd32768;
  assign p16_2_d     = poly_rnd[35:16];
  assign cube_raw2_d = 48'(sq1_q) * 48'(f1_q);
  assign diff2_d     = 22'(gb1_q) - 22'(ga1_q);

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      cube_raw2_q <= cube_raw2_d;
      p16_2_q     <= p16_2_d;
      ga2_q       <= ga1_q;
      diff2_q     <= diff2_d;
    end
  end

  // --------------------------------------------------------------------------
  // stage 3: t^3 rounded to q32
  // --------------------------------------------------------------------------

  assign cube_rnd = cube_raw2_q + 48'd32768;
  assign cube3_d  = cube_rnd[47:16];

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      cube3_q <= cube3_d;
      p16_3_q <= p16_2_q;
      ga3_q   <= ga2_q;
      diff3_q <= diff2_q;
    end
  end

  // --------------------------------------------------------------------------
  // stage 4: t^3 * poly
  // --------------------------------------------------------------------------

  assign uprod4_d = 52'(cube3_q) * 52'(p16_3_q);

  always_ff @(posedge clk_i) begin
    if (adv[4]) begin
      uprod4_q <= uprod4_d;
      ga4_q    <= ga3_q;
      diff4_q  <= diff3_q;
    end
  end

  // --------------------------------------------------------------------------
  // stage 5: fade weight, 0..1.0 in q16
  // --------------------------------------------------------------------------

  assign uprod_rnd = uprod4_q + 52'h0_0000_8000_0000;
  assign u5_d      = uprod_rnd[48:32];

  always_ff @(posedge clk_i) begin
    if (adv[5]) begin
      u5_q    <= u5_d;
      ga5_q   <= ga4_q;
      diff5_q <= diff4_q;
    end
  end

  // --------------------------------------------------------------------------
  // stage 6: u * (gb - ga)
  // --------------------------------------------------------------------------

  assign u_s  = $signed({1'b0, u5_q});
  assign m6_d = 40'(u_s) * 40'(diff5_q);

  always_ff @(posedge clk_i) begin
    if (adv[6]) begin
      m6_q  <= m6_d;
      ga6_q <= ga5_q;
    end
  end

  // --------------------------------------------------------------------------
  // stage 7: blend = ga + round(m / 2^16), noise = 2 * blend - 1.0
  // --------------------------------------------------------------------------

  // arithmetic shift floors toward minus infinity
  assign m_rnd   = (m6_q + 40'sd32768) >>> FracW;
  assign blend   = NoiseW'(ga6_q) + m_rnd[NoiseW-1:0];
  assign noise_d = (blend <<< 1) - $signed(NoiseW'(1 << FracW));

  always_ff @(posedge clk_i) begin
    if (adv[7]) begin
      noise_q <= noise_d;
    end
  end

  assign rsp_o.valid       = valid_q[NumStages-1];
  assign rsp_o.noise_value = noise_q;

endmodule

### hdl/gn1d_checker.sv
// ----------------------------------------------------------------------------
// gn1d_checker
// port-level checks of the noise block, bound to the top level
// ----------------------------------------------------------------------------
module gn1d_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           req_valid_i,
  input logic                           req_ready_i,
  input logic [gn1d_pkg::ActionW-1:0]   req_action_i,
  input logic                           rsp_valid_i,
  input logic                           rsp_ready_i,
  input logic [gn1d_pkg::NoiseW-1:0]    rsp_noise_i
);
  import gn1d_pkg::*;

  logic eval_acc;

  assign eval_acc = req_valid_i && req_ready_i &&
                    (action_e'(req_action_i) == ActEval);

  // a stalled result stays
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("result beat dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> $stable(rsp_noise_i))
    else $error("result payload changed while stalled");

  // an empty output register never backs up the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rsp_valid_i |-> req_ready_i)
    else $error("input blocked with empty output");

  // with the sink always ready an evaluate result is never held back in the pipeline
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    eval_acc ##1 rsp_ready_i ##1 rsp_ready_i ##1 rsp_ready_i ##1 rsp_ready_i
      ##1 rsp_ready_i ##1 rsp_ready_i ##1 rsp_ready_i |=> rsp_valid_i)
    else $error("evaluate result missing at full rate");

endmodule

bind gradient_noise_1d gn1d_checker u_gn1d_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .req_action_i (req_i.action),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_noise_i  (rsp_o.noise_value)
);

### tb/gradient_noise_1d_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gradient_noise_1d_tb
// self-checking bench: permutation table loads and noise evaluations are fed
// through the req channel under random pacing and output stalls, and every
// noise beat is compared against a fixed-point prediction kept in the bench
// ----------------------------------------------------------------------------
module gradient_noise_1d_tb;
  import gn1d_pkg::*;

  localparam int unsigned WatchdogLimit = 2000;  // cycles with no beat at all
  localparam int unsigned HoldCycles    = 60;    // long output hold-off
  localparam longint      OneQ16        = 65536;

  typedef enum {RxAlways, RxRandom, RxBursty} rx_mode_e;

  // one outstanding noise result, oldest at the front
  typedef struct {
    logic [CoordW-1:0]        coord;
    logic signed [NoiseW-1:0] noise;
  } noise_expect_t;

  logic clk = 1'b0;
  logic rst_n;

  gn1d_req_if req_if ();
  gn1d_rsp_if rsp_if ();

  gradient_noise_1d dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always #5 clk = ~clk;

  // predictor copy of the permutation table, written at each accepted load beat
  logic [EntryValueW-1:0] shadow_perm [TableEntries];
  noise_expect_t          pending_noise [$];

  // driver-side view of which entries have been loaded, so that no evaluate
  // ever reads an entry that was never written
  bit perm_loaded [TableEntries];

  int unsigned fail_count;
  int unsigned loads_sent;
  int unsigned evals_sent;
  int unsigned results_checked;
  int unsigned idle_count;

  // receiver controls
  rx_mode_e rx_mode = RxAlways;
  bit       hold_request;

  // sender pacing
  bit          tx_gaps;
  int unsigned burst_left;

  // --------------------------------------------------------------------------
  // prediction
  // --------------------------------------------------------------------------

  // signed gradient: bits 2..0 give magnitude 1..8, bit 3 flips the sign
  function automatic longint gradient_of(logic [EntryValueW-1:0] entry);
    longint g;
    g = 1 + longint'(entry[2:0]);
    if (entry[3]) g = -g;
    return g;
  endfunction

  function automatic logic signed [NoiseW-1:0] noise_at(logic [CoordW-1:0] coord);
    idx_t            i0;
    idx_t            i1;
    longint unsigned f;
    longint unsigned poly;
    longint unsigned p16;
    longint unsigned cube;
    longint unsigned fade;
    longint          ga;
    longint          gb;
    longint          blend;
    longint          scaled;
    i0 = idx_t'(coord >> FracW);
    i1 = i0 + idx_t'(1);  // last entry wraps back to entry zero
    f  = longint'(coord[FracW-1:0]);
    // quintic fade 6t^5 - 15t^4 + 10t^3, evaluated as t^3 * (10 - 15t + 6t^2)
    poly = (64'd10 << 32) + 64'd6 * f * f - 64'd15 * f * 64'd65536;
    p16  = (poly + 64'd32768) >> 16;
    cube = (f * f * f + 64'd32768) >> 16;
    fade = (cube * p16 + 64'd2147483648) >> 32;
    ga = gradient_of(shadow_perm[i0]) * longint'(f);
    gb = gradient_of(shadow_perm[i1]) * (longint'(f) - OneQ16);
    // rounded blend, floor semantics for negative products
    blend  = ga + ((longint'(fade) * (gb - ga) + 64'sd32768) >>> 16);
    scaled = 2 * blend - OneQ16;
    return scaled[NoiseW-1:0];
  endfunction

  // --------------------------------------------------------------------------
  // beat monitor: predicts on req beats and checks rsp beats
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    noise_expect_t exp_beat;
    if (rst_n === 1'b1 && req_if.valid === 1'b1 && req_if.ready === 1'b1) begin
      if (req_if.action == ActLoad) begin
        shadow_perm[idx_t'(req_if.entry_index)] <= req_if.entry_value;
      end else begin
        exp_beat.coord = req_if.coordinate;
        exp_beat.noise = noise_at(req_if.coordinate);
        pending_noise.push_back(exp_beat);
      end
    end
    if (rst_n === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      if (pending_noise.size() == 0) begin
        $display("%0t unexpected noise beat: expected none, got %0d",
                 $time, rsp_if.noise_value);
        fail_count++;
      end else begin
        exp_beat = pending_noise.pop_front();
        results_checked++;
        if (rsp_if.noise_value !== exp_beat.noise) begin
          $display("%0t noise mismatch at coordinate %h: expected %0d, got %0d",
                   $time, exp_beat.coord, exp_beat.noise, rsp_if.noise_value);
          fail_count++;
        end
      end
    end
  end

  // the shadow table is written by nonblocking assignment, so a load and an
  // evaluate in back-to-back beats still see each other in order: the load is
  // accepted at an earlier edge than the evaluate that follows it

  // --------------------------------------------------------------------------
  // watchdog: ends the run when neither channel moves a beat for too long
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
          (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)) begin
        idle_count <= 0;
      end else if (idle_count >= WatchdogLimit) begin
        $display("%0t watchdog: no beat for %0d cycles, %0d results outstanding",
                 $time, WatchdogLimit, pending_noise.size());
        $display("[gradient_noise_1d] ERROR");
        $finish;
      end else begin
        idle_count <= idle_count + 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // receiver: stall pattern of its own, plus a long hold-off on request
  // --------------------------------------------------------------------------
  initial begin
    int unsigned hold_left;
    int unsigned run_left;
    bit          rx_on;
    hold_left = 0;
    run_left  = 0;
    rx_on     = 1'b1;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        case (rx_mode)
          RxAlways: begin
            rsp_if.ready <= 1'b1;
          end
          RxRandom: begin
            rsp_if.ready <= ($urandom_range(0, 3) != 0);
          end
          default: begin
            // alternating runs of ready and stall of random length
            if (run_left == 0) begin
              rx_on    = !rx_on;
              run_left = $urandom_range(1, 8);
            end
            run_left--;
            rsp_if.ready <= rx_on;
          end
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // sender
  // --------------------------------------------------------------------------

  // drops valid and idles, n being the length of the gap; always called right after a rising edge
  task automatic idle_cycles(int unsigned n);
    req_if.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // offers one beat and waits for the edge that accepts it, then for any gap that follows
  task automatic send_beat(action_e act, logic [EntryIndexW-1:0] idx,
                           logic [EntryValueW-1:0] val, logic [CoordW-1:0] coord);
    req_if.valid       <= 1'b1;
    req_if.action      <= act;
    req_if.entry_index <= idx;
    req_if.entry_value <= val;
    req_if.coordinate  <= coord;
    do @(posedge clk); while (req_if.ready !== 1'b1);
    // bursts of random length with random gaps in between
    if (tx_gaps) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 6));
      end else begin
        burst_left--;
      end
    end
  endtask

  // unused fields carry random bits, which the block must ignore
  task automatic load_entry(logic [EntryIndexW-1:0] idx, logic [EntryValueW-1:0] val);
    perm_loaded[idx_t'(idx)] = 1'b1;
    loads_sent++;
    send_beat(ActLoad, idx, val, $urandom);
  endtask

  // pairs that touch an unloaded entry are skipped
  task automatic eval_at(logic [CoordW-1:0] coord);
    idx_t i0;
    i0 = idx_t'(coord >> FracW);
    if (perm_loaded[i0] && perm_loaded[idx_t'(i0 + idx_t'(1))]) begin
      evals_sent++;
      send_beat(ActEval, EntryIndexW'($urandom), EntryValueW'($urandom), coord);
    end
  endtask

  // random coordinate over loaded pairs, biased toward fraction corners and an all-ones integer part
  function automatic logic [CoordW-1:0] pick_coord();
    logic [CoordW-1:0] c;
    idx_t              i0;
    do begin
      c = $urandom;
      case ($urandom_range(0, 7))
        0: c[FracW-1:0] = '0;
        1: c[FracW-1:0] = '1;
        2: c[FracW-1:0] = 16'h8000;
        3: c[FracW-1:0] = FracW'($urandom_range(0, 15));
        4: c[CoordW-1:FracW] = '1;
        default: ;
      endcase
      i0 = idx_t'(c >> FracW);
    end while (!(perm_loaded[i0] && perm_loaded[idx_t'(i0 + idx_t'(1))]));
    return c;
  endfunction

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // gradient extremes, fraction corners, index masking and the wrap from the
  // last entry to entry zero
  task automatic test_directed_corners();
    rx_mode = RxRandom;
    tx_gaps = 1'b0;
    load_entry(8'd0,   8'h00);  // +1
    load_entry(8'd1,   8'hFF);  // -8, upper bits ignored
    load_entry(8'd2,   8'h07);  // +8
    load_entry(8'd3,   8'h08);  // -1
    load_entry(8'd254, 8'h80);  // +1, upper bit ignored
    load_entry(8'd255, 8'hF7);  // +8
    eval_at(32'h0000_0000);     // zero fraction
    eval_at(32'h0000_FFFF);     // fraction just below one
    eval_at(32'h0001_8000);     // midpoint between the two largest slopes
    eval_at(32'h0002_0001);
    eval_at(32'h0003_4000);     // neighbor entry 4 not loaded yet, so skipped
    eval_at(32'h00FE_C000);
    eval_at(32'h00FF_0000);     // last entry, neighbor wraps to zero
    eval_at(32'h00FF_FFFF);
    eval_at(32'hFFFF_FFFF);     // all ones, integer part masked
    eval_at(32'h0100_4000);     // integer part beyond the table, masked to zero
    load_entry(8'd0,   8'hA5);  // overwrite, then read it right away
    eval_at(32'h0000_8000);
    eval_at(32'h00FF_8000);
  endtask

  // every entry once, in shuffled order, with random values
  task automatic test_table_fill();
    logic [EntryIndexW-1:0] order [256];
    logic [EntryIndexW-1:0] swap;
    int unsigned            j;
    rx_mode = RxBursty;
    tx_gaps = 1'b1;
    for (int k = 0; k < 256; k++) order[k] = EntryIndexW'(k);
    for (int k = 255; k > 0; k--) begin
      j        = $urandom_range(0, k);
      swap     = order[k];
      order[k] = order[j];
      order[j] = swap;
    end
    for (int k = 0; k < 256; k++) load_entry(order[k], EntryValueW'($urandom));
  endtask

  // mostly evaluations, with table rewrites and load-then-read pairs mixed in
  task automatic test_random_mix(int unsigned n_items);
    int unsigned            sent;
    logic [EntryIndexW-1:0] k;
    logic [CoordW-1:0]      c;
    sent = 0;
    while (sent < n_items) begin
      // change the output pattern and pacing every hundred or so beats
      case ((sent / 110) % 4)
        0: rx_mode = RxRandom;
        1: rx_mode = RxBursty;
        2: rx_mode = RxAlways;
        default: rx_mode = RxRandom;
      endcase
      tx_gaps = ((sent / 110) % 4) != 2;
      case ($urandom_range(0, 9))
        0, 1: begin
          load_entry(EntryIndexW'($urandom), EntryValueW'($urandom));
          sent++;
        end
        2: begin
          // rewrite an entry and read it back at once, as low or high neighbor
          k = EntryIndexW'($urandom);
          load_entry(k, EntryValueW'($urandom));
          c = $urandom;
          c[CoordW-1:FracW] = (CoordW-FracW)'(CoordW'(k) - $urandom_range(0, 1));
          eval_at(c);
          sent += 2;
        end
        default: begin
          eval_at(pick_coord());
          sent++;
        end
      endcase
    end
  endtask

  // output held off for a long stretch while the sender keeps offering, so the
  // pipeline fills and stalls the input; then it drains at full rate
  task automatic test_output_backpressure(int unsigned n_items);
    rx_mode      = RxAlways;
    tx_gaps      = 1'b0;
    hold_request = 1'b1;
    repeat (n_items) eval_at(pick_coord());
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n              <= 1'b0;
    req_if.valid       <= 1'b0;
    req_if.action      <= ActLoad;
    req_if.entry_index <= '0;
    req_if.entry_value <= '0;
    req_if.coordinate  <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_corners();
    test_table_fill();
    test_random_mix(440);
    test_output_backpressure(40);

    // drain: wait for every expected result, then idle on so that any extra beat would still be caught
    idle_cycles(1);
    while (pending_noise.size() != 0) @(posedge clk);
    repeat (NumStages + 4) @(posedge clk);

    $display("covered %0d table loads and %0d evaluations, %0d noise beats checked",
             loads_sent, evals_sent, results_checked);
    $display("under random pacing, output stalls and a %0d-cycle hold-off; %0d mismatches",
             HoldCycles, fail_count);
    if (fail_count == 0 && pending_noise.size() == 0) begin
      $display("[gradient_noise_1d] OK");
    end else begin
      $display("[gradient_noise_1d] ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/gn1d_pkg.sv
hdl/gn1d_if.sv
hdl/gradient_noise_1d.sv
hdl/gn1d_checker.sv
tb/gradient_noise_1d_tb.sv
